// ===== hw/rtl/npc_pkg.sv =====
// Shared types and codes for the near-plane triangle clipper.
// No dependencies.
package npc_pkg;

  localparam int CoordW = 32;
  localparam int FracW  = 16;
  localparam int QDepth = 2;

  // Kinds of work that the front hands to the back
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vtx_t;

  // Queue entry: kind plus vertices in canonical order.
  // ONE: s0 inside, s1/s2 outside (index order); crossings s0->s1, s0->s2.
  // TWO: s0 = i1, s1 = i2, s2 = outside; crossings s0->s2, s1->s2.
  typedef struct packed {
    logic [1:0] kind;
    vtx_t       s0;
    vtx_t       s1;
    vtx_t       s2;
  } entry_t;

endpackage

// ===== hw/rtl/npc_if.sv =====
// Item channel interfaces for the clipper: triangle in, triangle out.
// Depends on npc_pkg.
interface npc_tri_if;
  logic                                valid;
  logic                                ready;
  logic signed [npc_pkg::CoordW-1:0]   ax, ay, az;
  logic signed [npc_pkg::CoordW-1:0]   bx, by_coord, bz;
  logic signed [npc_pkg::CoordW-1:0]   cx, cy, cz;
  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface npc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [npc_pkg::CoordW-1:0]   out_ax, out_ay, out_az;
  logic signed [npc_pkg::CoordW-1:0]   out_bx, out_by, out_bz;
  logic signed [npc_pkg::CoordW-1:0]   out_cx, out_cy, out_cz;
  logic                                last_piece;
  modport source (output valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                  out_cx, out_cy, out_cz, last_piece, input ready);
  modport sink   (input valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz,
                  out_cx, out_cy, out_cz, last_piece, output ready);
endinterface

// ===== hw/rtl/npc_front.sv =====
// Front: classifies a triangle against the near plane and reorders its vertices.
// Depends on npc_pkg.
module npc_front (
  input  npc_pkg::vtx_t                   v0,
  input  npc_pkg::vtx_t                   v1,
  input  npc_pkg::vtx_t                   v2,
  input  logic signed [npc_pkg::CoordW-1:0] near_z,
  output logic                            keep,
  output npc_pkg::entry_t                 ent
);

  logic [2:0] in_view;

  assign in_view[0] = v0.z >= near_z;
  assign in_view[1] = v1.z >= near_z;
  assign in_view[2] = v2.z >= near_z;

  // Pick kind and canonical vertex order
  always_comb begin
    keep    = 1'b1;
    ent     = '{kind: npc_pkg::KIND_PASS, s0: v0, s1: v1, s2: v2};
    case (in_view)
      3'b000: keep = 1'b0;
      3'b111: ent.kind = npc_pkg::KIND_PASS;
      3'b001: ent = '{kind: npc_pkg::KIND_ONE, s0: v0, s1: v1, s2: v2};
      3'b010: ent = '{kind: npc_pkg::KIND_ONE, s0: v1, s1: v0, s2: v2};
      3'b100: ent = '{kind: npc_pkg::KIND_ONE, s0: v2, s1: v0, s2: v1};
      3'b110: ent = '{kind: npc_pkg::KIND_TWO, s0: v1, s1: v2, s2: v0};
      3'b101: ent = '{kind: npc_pkg::KIND_TWO, s0: v2, s1: v0, s2: v1};
      3'b011: ent = '{kind: npc_pkg::KIND_TWO, s0: v0, s1: v1, s2: v2};
      default: keep = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/npc_queue.sv =====
// Two-entry queue between the front and the back.
// Depends on npc_pkg.
module npc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  npc_pkg::entry_t push_ent,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output npc_pkg::entry_t head
);

  npc_pkg::entry_t ents [npc_pkg::QDepth];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  assign full  = count == 2'(npc_pkg::QDepth);
  assign empty = count == 2'd0;
  assign head  = ents[rp];

  // Storage
  always_ff @(posedge clk) begin
    if (push) ents[wp] <= push_ent;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/npc_back.sv =====
// Back: computes edge crossings with a bit-serial divider and emits triangles.
// Depends on npc_pkg.
module npc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  npc_pkg::entry_t                   q_head,
  output logic                              q_pop,
  input  logic signed [npc_pkg::CoordW-1:0] near_z,
  output logic                              res_valid,
  input  logic                              res_ready,
  output npc_pkg::vtx_t                     res_a,
  output npc_pkg::vtx_t                     res_b,
  output npc_pkg::vtx_t                     res_c,
  output logic                              res_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT0 = 3'd4;
  localparam logic [2:0] S_EMIT1 = 3'd5;

  localparam int DW = npc_pkg::CoordW + 1;
  localparam int PW = DW + npc_pkg::FracW + 1;

  logic [2:0]                     state;
  logic                           xsel;
  logic [3:0]                     step;
  logic [DW:0]                    rem;
  logic [DW-1:0]                  den;
  logic [npc_pkg::FracW-1:0]      t;
  npc_pkg::vtx_t                  vin;
  npc_pkg::vtx_t                  vout;
  npc_pkg::vtx_t                  p1;
  npc_pkg::vtx_t                  p2;
  logic signed [PW-1:0]           prod [3];

  logic                           out_free;
  logic                           fire;
  npc_pkg::vtx_t                  nin;
  npc_pkg::vtx_t                  nout;
  logic [DW:0]                    rem_sh;
  logic                           fits;
  logic signed [npc_pkg::CoordW-1:0] cin  [3];
  logic signed [npc_pkg::CoordW-1:0] cout [3];
  logic signed [npc_pkg::CoordW-1:0] cres [3];

  assign out_free = !res_valid || res_ready;
  assign fire     = ((state == S_EMIT0) || (state == S_EMIT1)) && out_free;

  // Operand select for the second crossing
  always_comb begin
    nin  = q_head.s0;
    nout = q_head.s2;
    if (q_head.kind == npc_pkg::KIND_TWO) nin = q_head.s1;
  end

  // Restoring divide step
  assign rem_sh = {rem[DW-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den};

  // Crossing coordinates: floor shift, add, saturate
  assign cin[0]  = vin.x;
  assign cin[1]  = vin.y;
  assign cin[2]  = vin.z;
  assign cout[0] = vout.x;
  assign cout[1] = vout.y;
  assign cout[2] = vout.z;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [DW+1:0] sum;
      sum = DW'(prod[k] >>> npc_pkg::FracW) + (DW+2)'(cin[k]);
      if (sum > (DW+2)'(signed'(32'h7fffffff)))      cres[k] = 32'h7fffffff;
      else if (sum < (DW+2)'(signed'(32'h80000000))) cres[k] = 32'h80000000;
      else                                           cres[k] = sum[npc_pkg::CoordW-1:0];
    end
  end

  assign q_pop = ((state == S_EMIT0) && out_free && (q_head.kind != npc_pkg::KIND_TWO)) ||
                 ((state == S_EMIT1) && out_free);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      xsel      <= 1'b0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= fire || (res_valid && !res_ready);
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            xsel <= 1'b0;
            state <= (q_head.kind == npc_pkg::KIND_PASS) ? S_EMIT0 : S_DIV;
            step <= '0;
          end
        end
        S_DIV: begin
          step <= step + 4'd1;
          if (step == 4'hf) state <= S_MUL;
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (!xsel) begin
            xsel  <= 1'b1;
            step  <= '0;
            state <= S_DIV;
          end else begin
            state <= S_EMIT0;
          end
        end
        S_EMIT0: begin
          if (out_free) begin
            state <= (q_head.kind == npc_pkg::KIND_TWO) ? S_EMIT1 : S_IDLE;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) || (state == S_ADD && !xsel)) begin
      vin  <= (state == S_IDLE) ? q_head.s0 : nin;
      vout <= (state == S_IDLE) ?
              ((q_head.kind == npc_pkg::KIND_ONE) ? q_head.s1 : q_head.s2) : nout;
      if (state == S_IDLE) begin
        rem <= {1'b0, DW'(q_head.s0.z) - DW'(near_z)};
        den <= DW'(q_head.s0.z) -
               DW'((q_head.kind == npc_pkg::KIND_ONE) ? q_head.s1.z : q_head.s2.z);
      end else begin
        rem <= {1'b0, DW'(nin.z) - DW'(near_z)};
        den <= DW'(nin.z) - DW'(nout.z);
      end
    end
    if (state == S_DIV) begin
      rem <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
      t   <= {t[npc_pkg::FracW-2:0], fits};
    end
    if (state == S_MUL) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= (PW'(signed'(DW'(cout[k]) - DW'(cin[k])))) *
                   PW'(signed'({1'b0, t}));
      end
    end
    if (state == S_ADD) begin
      if (!xsel) p1 <= '{x: cres[0], y: cres[1], z: cres[2]};
      else       p2 <= '{x: cres[0], y: cres[1], z: cres[2]};
    end
    if (state == S_EMIT0 && out_free) begin
      res_last <= q_head.kind != npc_pkg::KIND_TWO;
      res_a    <= q_head.s0;
      case (q_head.kind)
        npc_pkg::KIND_PASS: begin
          res_b <= q_head.s1;
          res_c <= q_head.s2;
        end
        npc_pkg::KIND_ONE: begin
          res_b <= p1;
          res_c <= p2;
        end
        default: begin
          res_b <= p1;
          res_c <= q_head.s1;
        end
      endcase
    end
    if (state == S_EMIT1 && out_free) begin
      res_last <= 1'b1;
      res_a    <= p1;
      res_b    <= p2;
      res_c    <= q_head.s1;
    end
  end

endmodule

// ===== hw/rtl/near_plane_triangle_clipper.sv =====
// Near-plane triangle clipper top level: APB register, front, queue, back.
// Depends on npc_pkg, npc_if, npc_front, npc_queue, npc_back.
//
// Usage: triangles enter on in_ch (valid/ready), results leave on out_ch.
// Each accepted triangle gives zero, one or two result triangles; the last
// one carries last_piece. A fully outside triangle gives none.
// The front classifies in the accept cycle and writes a two-entry queue, so
// in_ch.ready stays high while the queue has room, even while out_ch stalls.
// A fully inside triangle goes straight to the output register. A clipped
// triangle takes two crossings, each computed with 16 divide steps in the
// one-bit-per-cycle divider, a multiply and an add stage; the back works on
// one triangle at a time and pops it from the queue with its last result.
// When out_ch.ready is low the result register holds its item and the back
// waits; the queue fills and then in_ch.ready drops.
// Reset (rst, synchronous) empties the queue and output and sets
// near_z to 6554. The register sits at APB address 0.
module near_plane_triangle_clipper (
  input  logic         clk,
  input  logic         rst,
  npc_tri_if.sink      in_ch,
  npc_res_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [1:0] ADDR_NEAR = 2'd0;

  logic signed [npc_pkg::CoordW-1:0] near_z;
  logic                              keep;
  npc_pkg::entry_t                   ent;
  logic                              q_full;
  logic                              q_empty;
  logic                              q_pop;
  npc_pkg::entry_t                   q_head;
  npc_pkg::vtx_t                     ra, rb, rc;
  npc_pkg::vtx_t                     in_v0, in_v1, in_v2;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NEAR) ? near_z : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      near_z <= 32'sd6554;
    end else if (psel && penable && pwrite && paddr == ADDR_NEAR) begin
      near_z <= pwdata;
    end
  end

  // Input vertices
  assign in_v0 = '{x: in_ch.ax, y: in_ch.ay, z: in_ch.az};
  assign in_v1 = '{x: in_ch.bx, y: in_ch.by_coord, z: in_ch.bz};
  assign in_v2 = '{x: in_ch.cx, y: in_ch.cy, z: in_ch.cz};

  npc_front u_front (
    .v0(in_v0),
    .v1(in_v1),
    .v2(in_v2),
    .near_z(near_z),
    .keep(keep),
    .ent(ent)
  );

  assign in_ch.ready = !q_full;

  npc_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_ch.valid && !q_full && keep),
    .push_ent(ent),
    .pop(q_pop),
    .full(q_full),
    .empty(q_empty),
    .head(q_head)
  );

  npc_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .near_z(near_z),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_a(ra), .res_b(rb), .res_c(rc),
    .res_last(out_ch.last_piece)
  );

  assign out_ch.out_ax = ra.x;
  assign out_ch.out_ay = ra.y;
  assign out_ch.out_az = ra.z;
  assign out_ch.out_bx = rb.x;
  assign out_ch.out_by = rb.y;
  assign out_ch.out_bz = rb.z;
  assign out_ch.out_cx = rc.x;
  assign out_ch.out_cy = rc.y;
  assign out_ch.out_cz = rc.z;

endmodule

// ===== hw/rtl/npc_checker.sv =====
// Port-level checks for the clipper, bound to the top level.
// Depends on near_plane_triangle_clipper and npc_if.
module npc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_ax
);

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ax))
    else $error("stalled result changed");

  // The second piece of a split follows the first at once
  a_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second piece missing");

endmodule

bind near_plane_triangle_clipper npc_checker u_npc_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last_piece), .out_ax(out_ch.out_ax)
);

// ===== bench/near_plane_triangle_clipper_tb.sv =====
// Testbench for near_plane_triangle_clipper: directed and random triangles,
// checked against a built-in clipping predictor. Depends on npc_pkg, npc_if.
module near_plane_triangle_clipper_tb;

  typedef struct {
    npc_pkg::vtx_t v0, v1, v2;
    logic last;
  } tri_res_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  localparam logic [1:0] ADDR_NEAR_Z = 2'd0;

  npc_tri_if in_ch ();
  npc_res_if out_ch ();

  near_plane_triangle_clipper dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // bench copy of the plane register
  longint plane_z;
  tri_res_t clipped_q[$];
  int mismatches;
  int failures;
  bit calm;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // one edge crossing, fraction in Q0.16
  function automatic logic signed [31:0] lerp(longint a, longint b, longint t);
    longint s;
    s = a + (((b - a) * t) >>> 16);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic npc_pkg::vtx_t crossing(npc_pkg::vtx_t vi, npc_pkg::vtx_t vo);
    longint num, den, t;
    npc_pkg::vtx_t r;
    num = longint'(vi.z) - plane_z;
    den = longint'(vi.z) - longint'(vo.z);
    t = (den != 0) ? (num <<< 16) / den : 0;
    if (t > 65535) t = 65535;
    r.x = lerp(vi.x, vo.x, t);
    r.y = lerp(vi.y, vo.y, t);
    r.z = lerp(vi.z, vo.z, t);
    return r;
  endfunction

  function automatic void push_tri(npc_pkg::vtx_t a, npc_pkg::vtx_t b, npc_pkg::vtx_t c,
                                   logic last);
    tri_res_t r;
    r.v0 = a; r.v1 = b; r.v2 = c; r.last = last;
    clipped_q = {clipped_q, r};
  endfunction

  // expected pieces for one accepted triangle
  function automatic void clip_triangle(npc_pkg::vtx_t v[3]);
    bit ins[3];
    int n, a, o1, o2, o;
    n = 0; a = 0; o1 = -1; o2 = -1; o = 0;
    for (int i = 0; i < 3; i++) begin
      ins[i] = longint'(v[i].z) >= plane_z;
      if (ins[i]) n++;
    end
    if (n == 3) begin
      push_tri(v[0], v[1], v[2], 1'b1);
    end else if (n == 1) begin
      for (int i = 0; i < 3; i++) begin
        if (ins[i]) a = i;
        else if (o1 < 0) o1 = i;
        else o2 = i;
      end
      push_tri(v[a], crossing(v[a], v[o1]), crossing(v[a], v[o2]), 1'b1);
    end else if (n == 2) begin
      o = !ins[0] ? 0 : (!ins[1] ? 1 : 2);
      push_tri(v[(o+1)%3], crossing(v[(o+1)%3], v[o]), v[(o+2)%3], 1'b0);
      push_tri(crossing(v[(o+1)%3], v[o]), crossing(v[(o+2)%3], v[o]),
               v[(o+2)%3], 1'b1);
    end
  endfunction

  // result side: random ready, long hold-off on request, field checks
  always @(posedge clk) begin
    tri_res_t e;
    logic signed [31:0] got[10], want[10];
    bit bad;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_ax, out_ch.out_ay, out_ch.out_az, out_ch.out_bx,
                out_ch.out_by, out_ch.out_bz, out_ch.out_cx, out_ch.out_cy,
                out_ch.out_cz, {31'd0, out_ch.last_piece}};
        if (clipped_q.size() == 0) begin
          failures++;
          if (mismatches < 10) $display("unexpected result item");
          mismatches++;
        end else begin
          e = clipped_q.pop_front();
          want = '{e.v0.x, e.v0.y, e.v0.z, e.v1.x, e.v1.y, e.v1.z,
                   e.v2.x, e.v2.y, e.v2.z, {31'd0, e.last}};
          bad = 0;
          for (int k = 0; k < 10; k++) begin
            if (got[k] !== want[k]) begin
              bad = 1;
              if (mismatches < 10)
                $display("mismatch field %0d: expected %0d actual %0d", k, want[k], got[k]);
            end
          end
          if (bad) begin
            failures++;
            mismatches++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  // offer one triangle, maybe after an idle gap; valid stays high between items
  task automatic send_tri(npc_pkg::vtx_t a, npc_pkg::vtx_t b, npc_pkg::vtx_t c);
    npc_pkg::vtx_t v[3];
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.ax, in_ch.ay, in_ch.az} <= a;
    {in_ch.bx, in_ch.by_coord, in_ch.bz} <= b;
    {in_ch.cx, in_ch.cy, in_ch.cz} <= c;
    do @(posedge clk); while (!in_ch.ready);
    v = '{a, b, c};
    clip_triangle(v);
  endtask

  // drop valid and let every expected piece and any quiet work finish
  task automatic drain();
    int n;
    in_ch.valid <= 1'b0;
    n = 0;
    while (clipped_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] val);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_NEAR_Z; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    plane_z = longint'(signed'(val));
  endtask

  function automatic npc_pkg::vtx_t mk(int x, int y, int z);
    npc_pkg::vtx_t r;
    r.x = x; r.y = y; r.z = z;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // depths cluster around the plane so every clip case shows up
  function automatic logic [31:0] rand_z();
    longint z;
    case ($urandom_range(3))
      0: return $urandom;
      3: z = plane_z + $signed($urandom_range(2)) - 1;
      default: z = plane_z + longint'($signed($urandom_range(2097152))) - 1048576;
    endcase
    if (z > 64'sd2147483647) z = 64'sd2147483647;
    if (z < -64'sd2147483648) z = -64'sd2147483648;
    return z[31:0];
  endfunction

  function automatic npc_pkg::vtx_t rand_vtx();
    return mk(rand_coord(), rand_coord(), rand_z());
  endfunction

  task automatic test_directed();
    int hi, lo, p, m;
    hi = 32'h7fff_ffff; lo = 32'h8000_0000; p = 6554; m = p - 1;
    // all outside, all inside, vertex exactly on plane
    send_tri(mk(1, 2, m), mk(3, 4, m), mk(5, 6, lo));
    send_tri(mk(hi, lo, p), mk(lo, hi, hi), mk(0, -1, p + 100));
    // one inside at each position
    send_tri(mk(65536, 0, 65536), mk(0, 65536, 0), mk(-65536, 0, -65536));
    send_tri(mk(0, 0, lo), mk(hi, lo, hi), mk(lo, hi, lo));
    send_tri(mk(7, 8, 0), mk(9, 10, -5), mk(11, 12, p));
    // two inside with outside at each position, then one all outside
    send_tri(mk(lo, lo, lo), mk(hi, hi, hi), mk(hi, lo, p));
    send_tri(mk(100, -100, hi), mk(lo, hi, m), mk(-3, 3, p + 1));
    send_tri(mk(65536, 65536, p + 65536), mk(-65536, 0, p), mk(hi, hi, lo));
    send_tri(mk(0, 0, -1), mk(-1, -1, -1), mk(0, 0, 0));
    // move the plane to its extremes, then to zero
    set_plane(32'h8000_0000);
    send_tri(mk(hi, hi, lo), mk(lo, lo, lo), mk(0, 0, hi));
    send_tri(mk(lo, hi, lo), mk(hi, lo, 0), mk(1, 1, -1));
    set_plane(32'h7fff_ffff);
    send_tri(mk(hi, lo, hi), mk(lo, hi, lo), mk(lo, lo, lo));
    send_tri(mk(lo, hi, hi), mk(hi, lo, hi), mk(0, 0, lo));
    send_tri(mk(1, 1, 0), mk(2, 2, hi - 1), mk(3, 3, -7));
    set_plane(32'd0);
    send_tri(mk(hi, hi, hi), mk(lo, lo, lo), mk(hi, lo, -1));
    send_tri(mk(lo, hi, 0), mk(hi, lo, lo), mk(lo, lo, hi));
    send_tri(mk(5, 5, -1), mk(6, 6, -2), mk(7, 7, -3));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2 && i < count / 2 + 30);
      send_tri(rand_vtx(), rand_vtx(), rand_vtx());
    end
    calm = 0;
  endtask

  task automatic test_backpressure();
    calm = 1;
    hold_cycles = 400;
    for (int i = 0; i < 10; i++)
      send_tri(mk($urandom, $urandom, int'(plane_z + 1 + i)), rand_vtx(), rand_vtx());
    calm = 0;
  endtask

  initial begin
    int n;
    plane_z = 6554;
    mismatches = 0; failures = 0; calm = 0; hold_cycles = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz,
     in_ch.cx, in_ch.cy, in_ch.cz} <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    set_plane(32'd6554);
    test_random(120);
    test_backpressure();
    set_plane($urandom);
    test_random(80);
    set_plane(32'hffff_0000);
    test_random(80);
    set_plane(32'h8000_0000);
    test_random(30);
    set_plane(32'h7fff_ffff);
    test_random(30);
    set_plane(32'd0);
    test_random(60);

    // wait out everything in flight
    in_ch.valid <= 1'b0;
    n = 0;
    while (clipped_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
    if (clipped_q.size() != 0) failures++;
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/npc_pkg.sv
hw/rtl/npc_if.sv
hw/rtl/npc_front.sv
hw/rtl/npc_queue.sv
hw/rtl/npc_back.sv
hw/rtl/near_plane_triangle_clipper.sv
hw/rtl/npc_checker.sv
bench/near_plane_triangle_clipper_tb.sv
